FILE: design/lnf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnf_pkg
// shared types and constants of the newline line framer
// ----------------------------------------------------------------------------
package lnf_pkg;

    // longest line that is kept, at most STORE_DEPTH
    localparam int MAX_LINE    = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(MAX_LINE + 1);

    localparam logic [7:0] BYTE_LF = 8'd10;
    localparam logic [7:0] BYTE_CR = 8'd13;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERLONG = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT
    } t_state;

    // request of the line store's write and read ports
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_store_req;

endpackage

FILE: design/lnf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnf_if
// request channels of the line framer: received bytes in, line items out
// ----------------------------------------------------------------------------
interface lnf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lnf_res_if;
    logic                valid;
    logic                ready;
    lnf_pkg::t_kind      kind;
    logic [7:0]          line_byte;
    logic                last;

    modport source (output valid, output kind, output line_byte, output last, input ready);
    modport sink   (input valid, input kind, input line_byte, input last, output ready);
endinterface

FILE: design/lnf_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnf_line_store
// line byte memory: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module lnf_line_store (
    input  logic                i_clk,
    input  lnf_pkg::t_store_req i_req,
    output logic [7:0]          o_rd_data
);

    logic [7:0] r_mem [lnf_pkg::STORE_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/newline_line_framer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newline_line_framer_top
// assembles line-feed terminated lines from a byte stream and plays them out
// ----------------------------------------------------------------------------
// Bytes come in on i_rx, one request each, and are written into a 64 entry
// line store (a single-port-write, registered-read memory). Carriage returns
// are ignored. A line feed plays the stored line out on o_res, one request
// per byte with last set on the final one; an empty line gives a single
// empty item. A byte that would make the line longer than MAX_LINE gives one
// overlong notice, clears the line and starts a drop that ends at the next
// line feed, which itself gives nothing. An ordinary byte, a carriage return
// and a line feed that ends an empty line or a drop are taken back to back.
// A line feed that ends a stored line holds i_rx off while the store is
// walked: each byte is read from the memory in S_READ and then loaded into
// the output register in S_WAIT, which waits while o_res stalls.
// A byte is taken only while the output register is free or being emptied.
// The store needs no clearing after reset: only entries written in the
// current line are ever read.
// ----------------------------------------------------------------------------
module newline_line_framer_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lnf_rx_if.sink           i_rx,
    lnf_res_if.source        o_res
);

    // control state
    lnf_pkg::t_state                 r_state, n_state;
    logic [lnf_pkg::LEN_W-1:0]       r_len, n_len;
    logic                            r_dropping, n_dropping;
    logic [lnf_pkg::ADDR_W-1:0]      r_idx, n_idx;

    // output register
    logic                            r_out_valid, n_out_valid;
    lnf_pkg::t_kind                  r_out_kind, n_out_kind;
    logic [7:0]                      r_out_byte, n_out_byte;
    logic                            r_out_last, n_out_last;

    // store access
    lnf_pkg::t_store_req             store_req;
    logic [7:0]                      store_rd_data;

    logic                            out_free;
    logic                            rx_fire;
    logic [lnf_pkg::LEN_W-1:0]       idx_next;

    lnf_line_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (store_rd_data)
    );

    // output register is free or drains this cycle
    assign out_free = !r_out_valid || o_res.ready;
    assign rx_fire  = i_rx.valid && i_rx.ready;
    // bytes only come in while the store is not being walked
    assign i_rx.ready = (r_state == lnf_pkg::S_IDLE) && out_free;

    // count of bytes played out once the current one is sent
    assign idx_next = lnf_pkg::LEN_W'(r_idx) + lnf_pkg::LEN_W'(1);

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_dropping  = r_dropping;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        store_req         = '0;
        store_req.wr_addr = lnf_pkg::ADDR_W'(r_len);
        store_req.wr_data = i_rx.rx_byte;
        store_req.rd_addr = r_idx;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lnf_pkg::S_IDLE: begin
                if (rx_fire) begin
                    if (i_rx.rx_byte == lnf_pkg::BYTE_LF) begin
                        if (r_dropping) begin
                            // line feed ends the drop quietly
                            n_dropping = 1'b0;
                            n_len      = '0;
                        end else if (r_len == '0) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = lnf_pkg::KIND_EMPTY;
                            n_out_byte  = '0;
                            n_out_last  = 1'b1;
                        end else begin
                            n_idx   = '0;
                            n_state = lnf_pkg::S_READ;
                        end
                    end else if (i_rx.rx_byte == lnf_pkg::BYTE_CR || r_dropping) begin
                        // ignored
                    end else if (r_len >= lnf_pkg::LEN_W'(lnf_pkg::MAX_LINE)) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = lnf_pkg::KIND_OVERLONG;
                        n_out_byte  = '0;
                        n_out_last  = 1'b1;
                        n_len       = '0;
                        n_dropping  = 1'b1;
                    end else begin
                        store_req.wr_en = 1'b1;
                        n_len           = r_len + lnf_pkg::LEN_W'(1);
                    end
                end
            end
            lnf_pkg::S_READ: begin
                // writes happen only in idle, so no read can meet a write
                store_req.rd_en = 1'b1;
                n_state         = lnf_pkg::S_WAIT;
            end
            lnf_pkg::S_WAIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = lnf_pkg::KIND_BYTE;
                    n_out_byte  = store_rd_data;
                    n_out_last  = (idx_next == r_len);
                    if (idx_next == r_len) begin
                        n_len   = '0;
                        n_state = lnf_pkg::S_IDLE;
                    end else begin
                        n_idx   = lnf_pkg::ADDR_W'(idx_next);
                        n_state = lnf_pkg::S_READ;
                    end
                end
            end
            default: begin
                n_state = lnf_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lnf_pkg::S_IDLE;
            r_len       <= '0;
            r_dropping  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_dropping  <= n_dropping;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_out_kind <= n_out_kind;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.kind      = r_out_kind;
    assign o_res.line_byte = r_out_byte;
    assign o_res.last      = r_out_last;

endmodule

FILE: design/lnf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnf_checker
// port-level checks of the line framer, bound to the top level
// ----------------------------------------------------------------------------
module lnf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_rx_valid,
    input logic           i_rx_ready,
    input logic [7:0]     i_rx_byte,
    input logic           i_res_valid,
    input logic           i_res_ready,
    input lnf_pkg::t_kind i_res_kind,
    input logic [7:0]     i_res_byte,
    input logic           i_res_last
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // no new byte while a result is stuck
    a_rx_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |-> !i_rx_ready)
        else $error("byte taken while output stalled");

    // empty and overlong notices stand alone with a zero byte
    a_notice_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_kind != lnf_pkg::KIND_BYTE |-> i_res_last && i_res_byte == 8'd0)
        else $error("malformed notice");

    // a carriage return never produces a result
    a_cr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rx_valid && i_rx_ready && i_rx_byte == lnf_pkg::BYTE_CR && !i_res_valid
        |=> !i_res_valid)
        else $error("result after carriage return");

endmodule

bind newline_line_framer_top lnf_checker u_lnf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_valid  (i_rx.valid),
    .i_rx_ready  (i_rx.ready),
    .i_rx_byte   (i_rx.rx_byte),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.kind),
    .i_res_byte  (o_res.line_byte),
    .i_res_last  (o_res.last)
);
